// ===== src/pid_aw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_aw_pkg
// Shared types, register indexes and the control store of the PID sequencer.
// ----------------------------------------------------------------------------
package pid_aw_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 4;
    localparam int DIV_BITS   = 17;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_CEILING = 3'd4;

    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_EDT  = 3'd1,
        MUL_P    = 3'd2,
        MUL_I    = 3'd3,
        MUL_D    = 3'd4
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    typedef enum logic [1:0] {
        C_NONE     = 2'd0,
        C_NO_INPUT = 2'd1,
        C_DIV_MORE = 2'd2,
        C_OUT_BUSY = 2'd3
    } t_cond;

    typedef struct packed {
        t_mul_sel           mul_sel;
        t_acc_op            acc_op;
        logic               isum_en;
        logic               clamp_en;
        logic               div_en;
        logic               dfix_en;
        logic               out_en;
        t_cond              cond;
        logic [STEP_W-1:0]  target;
        logic               last;
    } t_uword;

    localparam logic [STEP_W-1:0] S_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] S_EDT   = 4'd1;
    localparam logic [STEP_W-1:0] S_ISUM  = 4'd2;
    localparam logic [STEP_W-1:0] S_CLAMP = 4'd3;
    localparam logic [STEP_W-1:0] S_DIV   = 4'd4;
    localparam logic [STEP_W-1:0] S_DFIX  = 4'd5;
    localparam logic [STEP_W-1:0] S_MULI  = 4'd6;
    localparam logic [STEP_W-1:0] S_MULD  = 4'd7;
    localparam logic [STEP_W-1:0] S_ADDD  = 4'd8;
    localparam logic [STEP_W-1:0] S_OUT   = 4'd9;

    function automatic t_uword uc_rom(input logic [STEP_W-1:0] addr);
        t_uword w;
        w = '{mul_sel: MUL_NONE, acc_op: ACC_NONE, isum_en: 1'b0, clamp_en: 1'b0,
              div_en: 1'b0, dfix_en: 1'b0, out_en: 1'b0, cond: C_NONE,
              target: S_WAIT, last: 1'b0};
        case (addr)
            S_WAIT: begin
                w.cond   = C_NO_INPUT;
                w.target = S_WAIT;
            end
            S_EDT:   w.mul_sel  = MUL_EDT;
            S_ISUM:  w.isum_en  = 1'b1;
            S_CLAMP: w.clamp_en = 1'b1;
            S_DIV: begin
                w.div_en = 1'b1;
                w.cond   = C_DIV_MORE;
                w.target = S_DIV;
            end
            S_DFIX: begin
                w.dfix_en = 1'b1;
                w.mul_sel = MUL_P;
            end
            S_MULI: begin
                w.mul_sel = MUL_I;
                w.acc_op  = ACC_LOAD;
            end
            S_MULD: begin
                w.mul_sel = MUL_D;
                w.acc_op  = ACC_ADD;
            end
            S_ADDD:  w.acc_op = ACC_ADD;
            S_OUT: begin
                w.out_en = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = S_OUT;
                w.last   = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== src/pid_controller_antiwindup_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A new input word is taken only at the wait step, so each word runs through
// every step of the control store before the next is accepted; the output step
// holds while the output word is held. The 17-step restoring divider for the
// derivative and the shared 32x32 multiplier (four products per word) set its length.
// Reset (synchronous, active low): gains 0, clamps at full range, integral
// and last error 0, sequencer at its wait step, no output word pending.
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_top
// Fixed-point PID controller with clamped integral, microcoded datapath.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_top
    import pid_aw_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // [15:0] target, [31:16] measured, [47:32] elapsed_ms
    input  wire [IN_DATA_W-1:0]     s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // [31:0] drive
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] out_saturated, [1] integ_clamped, [2] zero_interval
    output logic [OUT_USER_W-1:0]   m_axis_tuser
);

    logic signed [31:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic signed [31:0] r_floor, r_ceil;

    logic [STEP_W-1:0]    r_step, n_step;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_uword               uw;

    logic signed [16:0]   r_err, r_last_err;
    logic [15:0]          r_dt;
    logic                 r_zdt, r_neg, r_clamped;
    logic signed [31:0]   r_integ;
    logic signed [33:0]   r_isum;
    logic [15:0]          r_rem;
    logic [DIV_BITS-1:0]  r_quo;
    logic signed [17:0]   r_deriv;
    logic signed [63:0]   r_prod, r_acc;

    logic                 in_fire, cond_hit;
    logic signed [16:0]   in_err;
    logic signed [17:0]   in_diff, in_mag;
    logic signed [31:0]   mul_a, mul_b;
    logic [16:0]          div_trial;
    logic                 div_ge;
    logic signed [33:0]   ceil_x, floor_x;
    logic                 sum_ovf;
    logic                 out_busy;

    assign uw            = uc_rom(r_step);
    assign s_axis_tready = (r_step == S_WAIT);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_busy      = m_axis_tvalid && !m_axis_tready;

    assign in_err  = 17'(signed'(s_axis_tdata[15:0])) - 17'(signed'(s_axis_tdata[31:16]));
    assign in_diff = 18'(in_err) - 18'(r_last_err);
    assign in_mag  = in_diff[17] ? -in_diff : in_diff;

    // sequencer
    always_comb begin
        case (uw.cond)
            C_NO_INPUT: cond_hit = !in_fire;
            C_DIV_MORE: cond_hit = (r_cnt != DIV_CNT_W'(DIV_BITS - 1));
            C_OUT_BUSY: cond_hit = out_busy;
            default:    cond_hit = 1'b0;
        endcase
        if (cond_hit) begin
            n_step = uw.target;
        end else if (uw.last) begin
            n_step = S_WAIT;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_floor      <= 32'sh8000_0000;
            r_ceil       <= 32'sh7FFF_FFFF;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PROP_GAIN:     r_prop_gain  <= i_cfg_data;
                REG_INTEG_GAIN:    r_integ_gain <= i_cfg_data;
                REG_DERIV_GAIN:    r_deriv_gain <= i_cfg_data;
                REG_INTEG_FLOOR:   r_floor      <= i_cfg_data;
                REG_INTEG_CEILING: r_ceil       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier
    always_comb begin
        case (uw.mul_sel)
            MUL_EDT: begin
                mul_a = signed'({16'd0, r_dt});
                mul_b = 32'(r_err);
            end
            MUL_P: begin
                mul_a = r_prop_gain;
                mul_b = 32'(r_err);
            end
            MUL_I: begin
                mul_a = r_integ_gain;
                mul_b = r_integ;
            end
            MUL_D: begin
                mul_a = r_deriv_gain;
                mul_b = 32'(r_deriv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_trial = {r_rem, r_quo[DIV_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dt});
    assign ceil_x    = 34'(r_ceil);
    assign floor_x   = 34'(r_floor);
    assign sum_ovf   = !((&r_acc[63:47]) || !(|r_acc[63:47]));

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_err  <= in_err;
            r_dt   <= s_axis_tdata[47:32];
            r_zdt  <= (s_axis_tdata[47:32] == 16'd0);
            r_neg  <= in_diff[17];
            r_quo  <= in_mag[DIV_BITS-1:0];
            r_rem  <= '0;
        end
        if (uw.mul_sel != MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        if (uw.isum_en) begin
            r_isum <= 34'(r_integ) + r_prod[33:0];
        end
        if (uw.div_en) begin
            r_rem <= div_ge ? 16'(div_trial - {1'b0, r_dt}) : div_trial[15:0];
            r_quo <= {r_quo[DIV_BITS-2:0], div_ge};
        end
        if (uw.dfix_en) begin
            if (r_zdt) begin
                r_deriv <= '0;
            end else if (r_neg) begin
                r_deriv <= -signed'({1'b0, r_quo});
            end else begin
                r_deriv <= signed'({1'b0, r_quo});
            end
        end
        case (uw.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default: ;
        endcase
    end

    // controller state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
            r_cnt      <= '0;
            r_clamped  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_last_err <= in_err;
                r_cnt      <= '0;
            end else if (uw.div_en) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (uw.clamp_en) begin
                if (r_isum > ceil_x) begin
                    r_integ   <= r_ceil;
                    r_clamped <= 1'b1;
                end else if (r_isum < floor_x) begin
                    r_integ   <= r_floor;
                    r_clamped <= 1'b1;
                end else begin
                    r_integ   <= r_isum[31:0];
                    r_clamped <= 1'b0;
                end
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (uw.out_en && !out_busy) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.out_en && !out_busy) begin
            if (sum_ovf) begin
                m_axis_tdata <= r_acc[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                m_axis_tdata <= r_acc[47:16];
            end
            m_axis_tuser <= {r_zdt, r_clamped, sum_ovf};
        end
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= S_OUT)
        else $error("sequencer step out of program");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_step) == S_OUT))
        else $error("output word raised outside output step");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_DIV && r_dt != 16'd0) |-> (r_rem < r_dt))
        else $error("divider remainder not below divisor");

    a_zdt_deriv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_MULI && r_zdt) |-> (r_deriv == 18'sd0))
        else $error("derivative not forced to zero");

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_step) == S_CLAMP && $past(r_floor) <= $past(r_ceil))
        |-> (r_integ <= $past(r_ceil) && r_integ >= $past(r_floor)))
        else $error("integral outside clamp window");
`endif

endmodule
`default_nettype wire
